// ===== src/rtlm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Round-trip latency monitor package
// Shared widths, reset values, codes, controller states and the candidate
// request opcode table.
// ----------------------------------------------------------------------------
package rtlm_pkg;

   localparam int OPERATION_WIDTH   = 2;
   localparam int OPCODE_WIDTH      = 16;
   localparam int LENGTH_WIDTH      = 16;
   localparam int EVENT_TIME_WIDTH  = 64;
   localparam int FREQ_WIDTH        = 32;
   localparam int LIMIT_WIDTH       = 24;
   localparam int RTT_WIDTH         = 25;
   localparam int CSR_INDEX_WIDTH   = 2;
   localparam int CSR_DATA_WIDTH    = 32;

   localparam int TIME_WIDTH_DEFAULT = 64;

   // elapsed ticks are always handled at full counter width
   localparam int TICKS_WIDTH     = 64;
   localparam int MUL_HALF_WIDTH  = TICKS_WIDTH / 2;
   localparam int US_WIDTH        = 20;
   localparam int PROD_HALF_WIDTH = MUL_HALF_WIDTH + US_WIDTH;
   localparam int PRODUCT_WIDTH   = TICKS_WIDTH + US_WIDTH;
   localparam int QUOT_WIDTH      = RTT_WIDTH;
   localparam int DIV_COUNT_WIDTH = $clog2(QUOT_WIDTH);
   localparam int HIGH_WIDTH      = PRODUCT_WIDTH - QUOT_WIDTH;

   localparam logic [US_WIDTH-1:0] US_PER_SECOND = US_WIDTH'(1000000);

   localparam logic [FREQ_WIDTH-1:0]   FREQ_RESET     = FREQ_WIDTH'(10000000);
   localparam logic [LIMIT_WIDTH-1:0]  LIMIT_RESET    = LIMIT_WIDTH'(1500 * 1000);
   localparam logic [OPCODE_WIDTH-1:0] RESP_OP_RESET  = 16'h007f;
   localparam logic [LENGTH_WIDTH-1:0] REQ_LEN_RESET  = LENGTH_WIDTH'(6);
   localparam logic signed [RTT_WIDTH-1:0] RTT_NONE   = '1;

   localparam int NUM_CANDIDATES   = 8;
   localparam int KNOWN_CANDIDATES = 8;
   localparam logic [OPCODE_WIDTH-1:0] CANDIDATE_TABLE [KNOWN_CANDIDATES] = '{
      16'h0363, 16'h0364, 16'h035f, 16'h0360,
      16'h0886, 16'h0887, 16'h0817, 16'h007e
   };

   typedef enum logic [OPERATION_WIDTH-1:0] {
      OP_SEND    = 2'd0,
      OP_RECEIVE = 2'd1,
      OP_MODE    = 2'd2
   } op_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_COUNTER_FREQUENCY = 2'd0,
      CSR_MAX_ROUND_TRIP    = 2'd1,
      CSR_RESPONSE_OPCODE   = 2'd2,
      CSR_REQUEST_LENGTH    = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_MUL_LO,
      S_MUL_HI,
      S_SUM,
      S_RANGE,
      S_DIVIDE,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic latch;
      logic decode;
      logic mul_lo;
      logic mul_hi;
      logic sum;
      logic range_check;
      logic div_step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic rx_start;
      logic range_ok;
      logic div_done;
   } status_type;

endpackage

// ===== src/rtlm_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Round-trip latency monitor channels
// Request and response channels with valid/ready handshake and payload.
// ----------------------------------------------------------------------------
interface rtlm_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [rtlm_pkg::OPERATION_WIDTH-1:0]  operation;
   logic [rtlm_pkg::OPCODE_WIDTH-1:0]     packet_opcode;
   logic [rtlm_pkg::LENGTH_WIDTH-1:0]     packet_length;
   logic [rtlm_pkg::EVENT_TIME_WIDTH-1:0] event_time;
   logic                                  entering_game;

   modport source (
      output valid, operation, packet_opcode, packet_length, event_time, entering_game,
      input  ready
   );
   modport sink (
      input  valid, operation, packet_opcode, packet_length, event_time, entering_game,
      output ready
   );
endinterface

interface rtlm_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [rtlm_pkg::RTT_WIDTH-1:0] last_rtt_us;
   logic [rtlm_pkg::OPCODE_WIDTH-1:0]    learned_request_opcode;
   logic                                 new_measurement;

   modport source (
      output valid, last_rtt_us, learned_request_opcode, new_measurement,
      input  ready
   );
   modport sink (
      input  valid, last_rtt_us, learned_request_opcode, new_measurement,
      output ready
   );
endinterface

// ===== src/rtlm_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Round-trip latency monitor controller
// Sequences decode, multiply, range check and division, and owns the
// request/response handshake.
// ----------------------------------------------------------------------------
module rtlm_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rtlm_pkg::cmd_type    cmd,
   input  rtlm_pkg::status_type status
);

   rtlm_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                req_take;
   logic                load_rsp;

   assign req_ready = (state_ff == rtlm_pkg::S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_take  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rtlm_pkg::S_IDLE: begin
            if (req_take) state_in = rtlm_pkg::S_DECODE;
         end
         rtlm_pkg::S_DECODE: begin
            state_in = status.rx_start ? rtlm_pkg::S_MUL_LO : rtlm_pkg::S_IDLE;
         end
         rtlm_pkg::S_MUL_LO: state_in = rtlm_pkg::S_MUL_HI;
         rtlm_pkg::S_MUL_HI: state_in = rtlm_pkg::S_SUM;
         rtlm_pkg::S_SUM:    state_in = rtlm_pkg::S_RANGE;
         rtlm_pkg::S_RANGE: begin
            state_in = status.range_ok ? rtlm_pkg::S_DIVIDE : rtlm_pkg::S_FINISH;
         end
         rtlm_pkg::S_DIVIDE: begin
            if (status.div_done) state_in = rtlm_pkg::S_FINISH;
         end
         rtlm_pkg::S_FINISH: state_in = rtlm_pkg::S_IDLE;
         default:            state_in = rtlm_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd      = '0;
      load_rsp = 1'b0;
      case (state_ff)
         rtlm_pkg::S_IDLE:   cmd.latch = req_take;
         rtlm_pkg::S_DECODE: begin
            cmd.decode = 1'b1;
            load_rsp   = !status.rx_start;
         end
         rtlm_pkg::S_MUL_LO: cmd.mul_lo      = 1'b1;
         rtlm_pkg::S_MUL_HI: cmd.mul_hi      = 1'b1;
         rtlm_pkg::S_SUM:    cmd.sum         = 1'b1;
         rtlm_pkg::S_RANGE:  cmd.range_check = 1'b1;
         rtlm_pkg::S_DIVIDE: cmd.div_step    = 1'b1;
         rtlm_pkg::S_FINISH: begin
            cmd.finish = 1'b1;
            load_rsp   = 1'b1;
         end
         default: cmd = '0;
      endcase
   end

   always_comb begin
      if (load_rsp) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rtlm_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_divide_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rtlm_pkg::S_DIVIDE && status.div_done) |=> (state_ff == rtlm_pkg::S_FINISH))
      else $error("divider did not hand over to finish");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |->
         ($past(state_ff) == rtlm_pkg::S_DECODE || $past(state_ff) == rtlm_pkg::S_FINISH))
      else $error("response raised outside decode or finish");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (state_ff != rtlm_pkg::S_IDLE) |-> !req_ready)
      else $error("request taken while busy");

endmodule

// ===== src/rtlm_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Round-trip latency monitor datapath
// Configuration registers, timer state, shared 32x20 multiplier and a
// radix-2 restoring divider for the tick-to-microsecond conversion.
// ----------------------------------------------------------------------------
module rtlm_datapath #(
   parameter int TIME_WIDTH = rtlm_pkg::TIME_WIDTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_en,
   input  logic [rtlm_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [rtlm_pkg::CSR_DATA_WIDTH-1:0]   csr_write_data,
   input  logic [rtlm_pkg::OPERATION_WIDTH-1:0]  req_operation,
   input  logic [rtlm_pkg::OPCODE_WIDTH-1:0]     req_packet_opcode,
   input  logic [rtlm_pkg::LENGTH_WIDTH-1:0]     req_packet_length,
   input  logic [rtlm_pkg::EVENT_TIME_WIDTH-1:0] req_event_time,
   input  logic                                  req_entering_game,
   input  rtlm_pkg::cmd_type                     cmd,
   output rtlm_pkg::status_type                  status,
   output logic signed [rtlm_pkg::RTT_WIDTH-1:0] rsp_last_rtt_us,
   output logic [rtlm_pkg::OPCODE_WIDTH-1:0]     rsp_learned_request_opcode,
   output logic                                  rsp_new_measurement
);

   localparam int OW  = rtlm_pkg::OPCODE_WIDTH;
   localparam int RW  = rtlm_pkg::RTT_WIDTH;
   localparam int FW  = rtlm_pkg::FREQ_WIDTH;
   localparam int TKW = rtlm_pkg::TICKS_WIDTH;
   localparam int MHW = rtlm_pkg::MUL_HALF_WIDTH;
   localparam int PHW = rtlm_pkg::PROD_HALF_WIDTH;
   localparam int PW  = rtlm_pkg::PRODUCT_WIDTH;
   localparam int QW  = rtlm_pkg::QUOT_WIDTH;
   localparam int HW  = rtlm_pkg::HIGH_WIDTH;
   localparam int CW  = rtlm_pkg::DIV_COUNT_WIDTH;

   // configuration
   logic [FW-1:0]                        freq_ff;
   logic [rtlm_pkg::LIMIT_WIDTH-1:0]     limit_ff;
   logic [OW-1:0]                        resp_op_ff;
   logic [rtlm_pkg::LENGTH_WIDTH-1:0]    req_len_ff;

   // latched request
   rtlm_pkg::op_type                     op_ff;
   logic [OW-1:0]                        opcode_ff;
   logic [rtlm_pkg::LENGTH_WIDTH-1:0]    length_ff;
   logic [TIME_WIDTH-1:0]                time_ff;
   logic                                 game_ff;

   // timer state
   logic                 armed_ff, armed_in;
   logic [TIME_WIDTH-1:0] send_time_ff, send_time_in;
   logic [OW-1:0]        pending_ff, pending_in;
   logic [OW-1:0]        learned_ff, learned_in;
   logic signed [RW-1:0] last_rtt_ff, last_rtt_in;
   logic                 fresh_in;

   // conversion
   logic [TKW-1:0] ticks_ff, ticks_in;
   logic [MHW-1:0] mul_word;
   logic [PHW-1:0] mul_result;
   logic [PHW-1:0] prod_lo_ff;
   logic [PHW-1:0] prod_hi_ff;
   logic [PW-1:0]  product_ff;
   logic [HW-1:0]  high_part;
   logic [QW-1:0]  low_part;
   logic [FW-1:0]  freq_eff;
   logic [FW-1:0]  rem_ff, rem_in;
   logic [FW:0]    partial;
   logic           partial_ge;
   logic [QW-1:0]  quot_ff;
   logic [CW-1:0]  count_ff;
   logic           reject_ff;
   logic           result_ok;

   logic           cand_hit;
   logic           send_ok;
   logic           load_rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         freq_ff    <= rtlm_pkg::FREQ_RESET;
         limit_ff   <= rtlm_pkg::LIMIT_RESET;
         resp_op_ff <= rtlm_pkg::RESP_OP_RESET;
         req_len_ff <= rtlm_pkg::REQ_LEN_RESET;
      end else if (csr_write_en) begin
         case (rtlm_pkg::csr_index_type'(csr_index))
            rtlm_pkg::CSR_COUNTER_FREQUENCY: freq_ff    <= csr_write_data;
            rtlm_pkg::CSR_MAX_ROUND_TRIP:    limit_ff   <= csr_write_data[rtlm_pkg::LIMIT_WIDTH-1:0];
            rtlm_pkg::CSR_RESPONSE_OPCODE:   resp_op_ff <= csr_write_data[OW-1:0];
            rtlm_pkg::CSR_REQUEST_LENGTH:    req_len_ff <= csr_write_data[rtlm_pkg::LENGTH_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_ff     <= rtlm_pkg::op_type'(req_operation);
         opcode_ff <= req_packet_opcode;
         length_ff <= req_packet_length;
         time_ff   <= req_event_time[TIME_WIDTH-1:0];
         game_ff   <= req_entering_game;
      end
   end

   assign freq_eff = (freq_ff == '0) ? FW'(1) : freq_ff;

   always_comb begin
      cand_hit = 1'b0;
      for (int i = 0; i < rtlm_pkg::KNOWN_CANDIDATES; i++) begin
         if (i < rtlm_pkg::NUM_CANDIDATES && rtlm_pkg::CANDIDATE_TABLE[i] == opcode_ff)
            cand_hit = 1'b1;
      end
   end

   assign send_ok = (length_ff == req_len_ff)
                    && ((learned_ff != '0) ? (opcode_ff == learned_ff) : cand_hit);

   assign status.rx_start = (op_ff == rtlm_pkg::OP_RECEIVE) && (opcode_ff == resp_op_ff)
                            && armed_ff;

   assign ticks_in = (time_ff > send_time_ff) ? TKW'(time_ff - send_time_ff) : '0;

   // shared multiplier: low half of the ticks, then the high half
   assign mul_word   = cmd.mul_hi ? ticks_ff[TKW-1:MHW] : ticks_ff[MHW-1:0];
   assign mul_result = PHW'(mul_word) * PHW'(rtlm_pkg::US_PER_SECOND);

   assign high_part       = product_ff[PW-1:QW];
   assign low_part        = product_ff[QW-1:0];
   assign status.range_ok = high_part < HW'(freq_eff);

   assign partial    = {rem_ff, low_part[count_ff]};
   assign partial_ge = partial >= {1'b0, freq_eff};
   always_comb begin
      if (partial_ge) rem_in = FW'(partial - {1'b0, freq_eff});
      else rem_in = partial[FW-1:0];
   end

   assign status.div_done = (count_ff == '0);
   assign result_ok       = !reject_ff && (quot_ff <= QW'(limit_ff));

   always_ff @(posedge clock) begin
      if (cmd.decode) ticks_ff <= ticks_in;
      if (cmd.mul_lo) prod_lo_ff <= mul_result;
      if (cmd.mul_hi) prod_hi_ff <= mul_result;
      if (cmd.sum) product_ff <= {prod_hi_ff, {MHW{1'b0}}} + PW'(prod_lo_ff);
      if (cmd.range_check) begin
         reject_ff <= !status.range_ok;
         rem_ff    <= high_part[FW-1:0];
         count_ff  <= CW'(QW - 1);
      end else if (cmd.div_step) begin
         rem_ff   <= rem_in;
         quot_ff  <= {quot_ff[QW-2:0], partial_ge};
         count_ff <= count_ff - CW'(1);
      end
   end

   always_comb begin
      armed_in     = armed_ff;
      send_time_in = send_time_ff;
      pending_in   = pending_ff;
      learned_in   = learned_ff;
      last_rtt_in  = last_rtt_ff;
      fresh_in     = 1'b0;
      if (cmd.decode) begin
         case (op_ff)
            rtlm_pkg::OP_SEND: begin
               if (send_ok) begin
                  pending_in   = opcode_ff;
                  send_time_in = time_ff;
                  armed_in     = 1'b1;
               end
            end
            rtlm_pkg::OP_RECEIVE: begin
               if (status.rx_start) armed_in = 1'b0;
            end
            rtlm_pkg::OP_MODE: begin
               if (!game_ff) begin
                  armed_in     = 1'b0;
                  send_time_in = '0;
                  last_rtt_in  = rtlm_pkg::RTT_NONE;
               end
            end
            default: ;
         endcase
      end
      if (cmd.finish && result_ok) begin
         if (learned_ff == '0 && pending_ff != '0) learned_in = pending_ff;
         last_rtt_in = signed'(quot_ff);
         fresh_in    = 1'b1;
      end
   end

   assign load_rsp = (cmd.decode && !status.rx_start) || cmd.finish;

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff     <= 1'b0;
         send_time_ff <= '0;
         pending_ff   <= '0;
         learned_ff   <= '0;
         last_rtt_ff  <= rtlm_pkg::RTT_NONE;
      end else begin
         armed_ff     <= armed_in;
         send_time_ff <= send_time_in;
         pending_ff   <= pending_in;
         learned_ff   <= learned_in;
         last_rtt_ff  <= last_rtt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_last_rtt_us            <= last_rtt_in;
         rsp_learned_request_opcode <= learned_in;
         rsp_new_measurement        <= fresh_in;
      end
   end

   a_rtt_range: assert property (@(posedge clock) disable iff (reset)
      !last_rtt_ff[RW-1] || (last_rtt_ff == rtlm_pkg::RTT_NONE))
      else $error("last round trip holds a negative value other than none");

   a_learned_sticky: assert property (@(posedge clock) disable iff (reset)
      (learned_ff != '0) |=> (learned_ff == $past(learned_ff)))
      else $error("learned opcode changed after lock-in");

   a_disarmed_in_convert: assert property (@(posedge clock) disable iff (reset)
      cmd.mul_lo |-> !armed_ff)
      else $error("timer still armed during conversion");

endmodule

// ===== src/round_trip_latency_monitor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Round-trip latency monitor
// Times request/reply packet pairs and reports the last round trip in
// microseconds together with the learned request opcode.
// ----------------------------------------------------------------------------
// One request at a time. A send, a mode change, an unused operation or a
// receive that does not stop the timer loads its response in the decode
// state. A receive that stops the timer runs through decode, two multiplier
// passes, product sum, range check, 25 divider steps and finish, or goes
// straight from range check to finish when the range check rules it out.
// A new request is taken once the block is idle and the response register
// is empty or being read in that cycle.
module round_trip_latency_monitor #(
   parameter int TIME_WIDTH = rtlm_pkg::TIME_WIDTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   rtlm_req_if.sink                             req_bus,
   rtlm_rsp_if.source                           rsp_bus,
   input  logic                                 csr_write_en,
   input  logic [rtlm_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [rtlm_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data
);

   rtlm_pkg::cmd_type    cmd;
   rtlm_pkg::status_type status;

   rtlm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd),
      .status    (status)
   );

   rtlm_datapath #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_datapath (
      .clock                      (clock),
      .reset                      (reset),
      .csr_write_en               (csr_write_en),
      .csr_index                  (csr_index),
      .csr_write_data             (csr_write_data),
      .req_operation              (req_bus.operation),
      .req_packet_opcode          (req_bus.packet_opcode),
      .req_packet_length          (req_bus.packet_length),
      .req_event_time             (req_bus.event_time),
      .req_entering_game          (req_bus.entering_game),
      .cmd                        (cmd),
      .status                     (status),
      .rsp_last_rtt_us            (rsp_bus.last_rtt_us),
      .rsp_learned_request_opcode (rsp_bus.learned_request_opcode),
      .rsp_new_measurement        (rsp_bus.new_measurement)
   );

endmodule

// ===== sim/tb_round_trip_latency_monitor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Round-trip latency monitor testbench
// Drives send, receive and mode-change requests through the request channel,
// mirrors the timer, opcode learning and microsecond conversion in a
// scoreboard, and compares every response field by field. Runs a directed
// opening, then random phases under several register settings and idling
// mixes, including a long response hold-off that backs up the request side.
// ----------------------------------------------------------------------------
module tb_round_trip_latency_monitor;

   localparam logic [rtlm_pkg::OPERATION_WIDTH-1:0] OP_UNUSED = 2'd3;
   localparam int QUIET_LIMIT     = 3000;
   localparam int SETTLE_CYCLES   = 40;
   localparam int ITEMS_PER_PHASE = 155;

   typedef struct packed {
      logic [rtlm_pkg::OPERATION_WIDTH-1:0]  operation;
      logic [rtlm_pkg::OPCODE_WIDTH-1:0]     packet_opcode;
      logic [rtlm_pkg::LENGTH_WIDTH-1:0]     packet_length;
      logic [rtlm_pkg::EVENT_TIME_WIDTH-1:0] event_time;
      logic                                  entering_game;
   } monitor_request_type;

   typedef struct packed {
      logic [rtlm_pkg::RTT_WIDTH-1:0]    last_rtt_us;
      logic [rtlm_pkg::OPCODE_WIDTH-1:0] learned_request_opcode;
      logic                              new_measurement;
   } latency_reading_type;

   class latency_scoreboard;
      logic [rtlm_pkg::FREQ_WIDTH-1:0]       counter_frequency;
      logic [rtlm_pkg::LIMIT_WIDTH-1:0]      max_round_trip_us;
      logic [rtlm_pkg::OPCODE_WIDTH-1:0]     response_opcode;
      logic [rtlm_pkg::LENGTH_WIDTH-1:0]     request_length;
      logic                                  timer_armed;
      logic [rtlm_pkg::EVENT_TIME_WIDTH-1:0] send_time;
      logic [rtlm_pkg::OPCODE_WIDTH-1:0]     pending_opcode;
      logic [rtlm_pkg::OPCODE_WIDTH-1:0]     learned_opcode;
      logic [rtlm_pkg::RTT_WIDTH-1:0]        last_round_trip;
      latency_reading_type                   expected_readings[$];
      int                                    errors;

      function void reset_state();
         counter_frequency = rtlm_pkg::FREQ_RESET;
         max_round_trip_us = rtlm_pkg::LIMIT_RESET;
         response_opcode   = rtlm_pkg::RESP_OP_RESET;
         request_length    = rtlm_pkg::REQ_LEN_RESET;
         timer_armed       = 1'b0;
         send_time         = '0;
         pending_opcode    = '0;
         learned_opcode    = '0;
         last_round_trip   = rtlm_pkg::RTT_NONE;
         errors            = 0;
         expected_readings.delete();
      endfunction

      function void write_register(rtlm_pkg::csr_index_type idx,
                                   logic [rtlm_pkg::CSR_DATA_WIDTH-1:0] data);
         case (idx)
            rtlm_pkg::CSR_COUNTER_FREQUENCY:
               counter_frequency = data[rtlm_pkg::FREQ_WIDTH-1:0];
            rtlm_pkg::CSR_MAX_ROUND_TRIP:
               max_round_trip_us = data[rtlm_pkg::LIMIT_WIDTH-1:0];
            rtlm_pkg::CSR_RESPONSE_OPCODE:
               response_opcode   = data[rtlm_pkg::OPCODE_WIDTH-1:0];
            rtlm_pkg::CSR_REQUEST_LENGTH:
               request_length    = data[rtlm_pkg::LENGTH_WIDTH-1:0];
            default: ;
         endcase
      endfunction

      function bit is_candidate(logic [rtlm_pkg::OPCODE_WIDTH-1:0] opcode);
         int i;
         for (i = 0; i < rtlm_pkg::NUM_CANDIDATES && i < rtlm_pkg::KNOWN_CANDIDATES; i++)
            if (rtlm_pkg::CANDIDATE_TABLE[i] == opcode) return 1'b1;
         return 1'b0;
      endfunction

      function int pending();
         return expected_readings.size();
      endfunction

      function void note_request(monitor_request_type rq);
         logic [95:0]                     product;
         logic [95:0]                     micros;
         logic [63:0]                     ticks;
         logic [rtlm_pkg::FREQ_WIDTH-1:0] divisor;
         logic                            fresh;
         bit                              match;
         latency_reading_type             reading;
         fresh = 1'b0;
         case (rq.operation)
            rtlm_pkg::OP_SEND: begin
               match = (rq.packet_length == request_length);
               if (match)
                  match = (learned_opcode != 0) ? (rq.packet_opcode == learned_opcode)
                                                : is_candidate(rq.packet_opcode);
               if (match) begin
                  pending_opcode = rq.packet_opcode;
                  send_time      = rq.event_time;
                  timer_armed    = 1'b1;
               end
            end
            rtlm_pkg::OP_RECEIVE: begin
               if (rq.packet_opcode == response_opcode && timer_armed) begin
                  timer_armed = 1'b0;
                  ticks   = (rq.event_time > send_time) ? rq.event_time - send_time : '0;
                  divisor = (counter_frequency == 0) ? rtlm_pkg::FREQ_WIDTH'(1)
                                                     : counter_frequency;
                  product = {32'd0, ticks} * 96'd1000000;
                  micros  = product / {64'd0, divisor};
                  if (micros <= {72'd0, max_round_trip_us}) begin
                     if (learned_opcode == 0 && pending_opcode != 0)
                        learned_opcode = pending_opcode;
                     last_round_trip = micros[rtlm_pkg::RTT_WIDTH-1:0];
                     fresh = 1'b1;
                  end
               end
            end
            rtlm_pkg::OP_MODE: begin
               if (!rq.entering_game) begin
                  timer_armed     = 1'b0;
                  send_time       = '0;
                  last_round_trip = rtlm_pkg::RTT_NONE;
               end
            end
            default: ;
         endcase
         reading.last_rtt_us            = last_round_trip;
         reading.learned_request_opcode = learned_opcode;
         reading.new_measurement        = fresh;
         expected_readings.push_back(reading);
      endfunction

      function void check_response(latency_reading_type got);
         latency_reading_type want;
         if (expected_readings.size() == 0) begin
            $display("%0t: unexpected response: expected none, actual rtt %0d opcode %h new %b",
                     $time, $signed(got.last_rtt_us), got.learned_request_opcode,
                     got.new_measurement);
            errors++;
            return;
         end
         want = expected_readings.pop_front();
         if (want.last_rtt_us !== got.last_rtt_us) begin
            $display("%0t: last_rtt_us expected %0d, actual %0d", $time,
                     $signed(want.last_rtt_us), $signed(got.last_rtt_us));
            errors++;
         end
         if (want.learned_request_opcode !== got.learned_request_opcode) begin
            $display("%0t: learned_request_opcode expected %h, actual %h", $time,
                     want.learned_request_opcode, got.learned_request_opcode);
            errors++;
         end
         if (want.new_measurement !== got.new_measurement) begin
            $display("%0t: new_measurement expected %b, actual %b", $time,
                     want.new_measurement, got.new_measurement);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic                                 csr_write_en;
   logic [rtlm_pkg::CSR_INDEX_WIDTH-1:0] csr_index;
   logic [rtlm_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data;

   rtlm_req_if req_bus ();
   rtlm_rsp_if rsp_bus ();

   latency_scoreboard sb;
   int sender_idle_pct;
   int receiver_stall_pct;
   int hold_request;
   int quiet_cycles;

   round_trip_latency_monitor uut (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_bus),
      .rsp_bus        (rsp_bus),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // receiver: random stalls plus an occasional long hold-off
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      monitor_request_type rq;
      latency_reading_type got;
      bit                  moved;
      if (!reset) begin
         moved = 1'b0;
         if (req_bus.valid && req_bus.ready) begin
            rq.operation     = req_bus.operation;
            rq.packet_opcode = req_bus.packet_opcode;
            rq.packet_length = req_bus.packet_length;
            rq.event_time    = req_bus.event_time;
            rq.entering_game = req_bus.entering_game;
            sb.note_request(rq);
            moved = 1'b1;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.last_rtt_us            = rsp_bus.last_rtt_us;
            got.learned_request_opcode = rsp_bus.learned_request_opcode;
            got.new_measurement        = rsp_bus.new_measurement;
            sb.check_response(got);
            moved = 1'b1;
         end
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: watchdog: no handshake for %0d cycles", $time, QUIET_LIMIT);
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   function automatic monitor_request_type make_request(
         logic [rtlm_pkg::OPERATION_WIDTH-1:0]  op,
         logic [rtlm_pkg::OPCODE_WIDTH-1:0]     opcode,
         logic [rtlm_pkg::LENGTH_WIDTH-1:0]     length,
         logic [rtlm_pkg::EVENT_TIME_WIDTH-1:0] stamp,
         logic                                  game);
      monitor_request_type rq;
      rq.operation     = op;
      rq.packet_opcode = opcode;
      rq.packet_length = length;
      rq.event_time    = stamp;
      rq.entering_game = game;
      return rq;
   endfunction

   function automatic logic [63:0] random_stamp();
      return {$urandom, $urandom};
   endfunction

   // enter and leave at a falling edge
   task automatic send_request(input monitor_request_type rq);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.operation     <= rq.operation;
      req_bus.packet_opcode <= rq.packet_opcode;
      req_bus.packet_length <= rq.packet_length;
      req_bus.event_time    <= rq.event_time;
      req_bus.entering_game <= rq.entering_game;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic settle();
      req_bus.valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(input rtlm_pkg::csr_index_type idx,
                                 input logic [rtlm_pkg::CSR_DATA_WIDTH-1:0] data);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= data;
      @(negedge clock);
      sb.write_register(idx, data);
   endtask

   task automatic send_noise();
      int roll;
      roll = $urandom_range(2);
      if (roll == 0)
         send_request(make_request(rtlm_pkg::OP_RECEIVE,
                      sb.response_opcode ^ 16'($urandom_range(16'hFFFF, 1)),
                      16'($urandom), random_stamp(), 1'($urandom)));
      else if (roll == 1)
         send_request(make_request(rtlm_pkg::OP_MODE, 16'($urandom), 16'($urandom),
                                   random_stamp(), 1'b1));
      else
         send_request(make_request(OP_UNUSED, 16'($urandom), 16'($urandom),
                                   random_stamp(), 1'($urandom)));
   endtask

   task automatic run_measurements(input int target_items);
      int                                counted;
      int                                roll;
      int unsigned                       want_us;
      logic [rtlm_pkg::FREQ_WIDTH-1:0]   freq_eff;
      logic [63:0]                       base;
      logic [63:0]                       ticks;
      logic [rtlm_pkg::OPCODE_WIDTH-1:0] send_op;
      logic [rtlm_pkg::LENGTH_WIDTH-1:0] length;
      counted = 0;
      while (counted < target_items) begin
         roll = $urandom_range(99);
         if (roll < 55) begin
            send_op = (sb.learned_opcode != 0) ? sb.learned_opcode
                      : rtlm_pkg::CANDIDATE_TABLE[$urandom_range(rtlm_pkg::KNOWN_CANDIDATES - 1)];
            base = ($urandom_range(4) == 0) ? 64'($urandom_range(1000)) : random_stamp();
            freq_eff = (sb.counter_frequency == 0) ? rtlm_pkg::FREQ_WIDTH'(1)
                                                   : sb.counter_frequency;
            want_us = ($urandom_range(4) != 0) ? $urandom_range(sb.max_round_trip_us)
                                               : $urandom_range(24'hFFFFFF);
            ticks = (64'(want_us) * 64'(freq_eff)) / 64'd1000000;
            if ($urandom_range(3) == 0) ticks += 64'($urandom_range(freq_eff / 1000000 + 1));
            if ($urandom_range(19) == 0) ticks = random_stamp();
            send_request(make_request(rtlm_pkg::OP_SEND, send_op, sb.request_length, base,
                                      1'($urandom)));
            if ($urandom_range(4) == 0) begin
               send_noise();
               counted++;
            end
            send_request(make_request(rtlm_pkg::OP_RECEIVE, sb.response_opcode,
                                      16'($urandom), base + ticks, 1'($urandom)));
            counted += 2;
         end else if (roll < 70) begin
            length = $urandom_range(1) ? sb.request_length : 16'($urandom);
            send_request(make_request(rtlm_pkg::OP_SEND, 16'($urandom), length,
                                      random_stamp(), 1'($urandom)));
            counted++;
         end else if (roll < 85) begin
            send_request(make_request(rtlm_pkg::OP_RECEIVE,
                         $urandom_range(1) ? sb.response_opcode : 16'($urandom),
                         16'($urandom), random_stamp(), 1'($urandom)));
            counted++;
         end else if (roll < 95) begin
            send_request(make_request(rtlm_pkg::OP_MODE, 16'($urandom), 16'($urandom),
                                      random_stamp(), 1'($urandom)));
            counted++;
         end else begin
            send_request(make_request(OP_UNUSED, 16'($urandom), 16'($urandom),
                                      random_stamp(), 1'($urandom)));
            counted++;
         end
      end
   endtask

   task automatic run_phase(input logic [rtlm_pkg::FREQ_WIDTH-1:0] freq,
                            input logic [rtlm_pkg::LIMIT_WIDTH-1:0] limit,
                            input logic [rtlm_pkg::OPCODE_WIDTH-1:0] resp_op,
                            input logic [rtlm_pkg::LENGTH_WIDTH-1:0] req_len,
                            input int idle_pct, input int stall_pct, input int hold);
      settle();
      write_register(rtlm_pkg::CSR_COUNTER_FREQUENCY, rtlm_pkg::CSR_DATA_WIDTH'(freq));
      write_register(rtlm_pkg::CSR_MAX_ROUND_TRIP, rtlm_pkg::CSR_DATA_WIDTH'(limit));
      write_register(rtlm_pkg::CSR_RESPONSE_OPCODE, rtlm_pkg::CSR_DATA_WIDTH'(resp_op));
      write_register(rtlm_pkg::CSR_REQUEST_LENGTH, rtlm_pkg::CSR_DATA_WIDTH'(req_len));
      csr_write_en <= 1'b0;
      @(negedge clock);
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      hold_request       = hold;
      run_measurements(ITEMS_PER_PHASE);
   endtask

   task automatic run_directed();
      int i;
      send_request(make_request(OP_UNUSED, 16'hFFFF, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1));
      send_request(make_request(rtlm_pkg::OP_RECEIVE, rtlm_pkg::RESP_OP_RESET, 16'd0, 64'd0,
                                1'b0));
      send_request(make_request(rtlm_pkg::OP_SEND, 16'h1234, rtlm_pkg::REQ_LEN_RESET, 64'd100,
                                1'b0));
      send_request(make_request(rtlm_pkg::OP_SEND, rtlm_pkg::CANDIDATE_TABLE[0], 16'd5,
                                64'd100, 1'b0));
      // arm at timestamp zero, ignore a foreign reply, then reject an overlong trip
      send_request(make_request(rtlm_pkg::OP_SEND, rtlm_pkg::CANDIDATE_TABLE[0],
                                rtlm_pkg::REQ_LEN_RESET, 64'd0, 1'b0));
      send_request(make_request(rtlm_pkg::OP_RECEIVE, 16'h0080, 16'd0, 64'd50, 1'b0));
      send_request(make_request(rtlm_pkg::OP_RECEIVE, rtlm_pkg::RESP_OP_RESET, 16'd0,
                                64'd20_000_000, 1'b0));
      for (i = 0; i < rtlm_pkg::KNOWN_CANDIDATES; i++)
         send_request(make_request(rtlm_pkg::OP_SEND, rtlm_pkg::CANDIDATE_TABLE[i],
                                   rtlm_pkg::REQ_LEN_RESET, 64'(1000 + i), 1'b0));
      // reply behind the send time: zero elapsed, learns the last candidate
      send_request(make_request(rtlm_pkg::OP_RECEIVE, rtlm_pkg::RESP_OP_RESET, 16'd0,
                                64'd500, 1'b0));
      send_request(make_request(rtlm_pkg::OP_SEND, rtlm_pkg::CANDIDATE_TABLE[0],
                                rtlm_pkg::REQ_LEN_RESET, 64'd10, 1'b0));
      send_request(make_request(rtlm_pkg::OP_SEND,
                                rtlm_pkg::CANDIDATE_TABLE[rtlm_pkg::KNOWN_CANDIDATES - 1],
                                rtlm_pkg::REQ_LEN_RESET, 64'hFFFF_FFFF_FFFF_0000, 1'b0));
      send_request(make_request(rtlm_pkg::OP_MODE, 16'd0, 16'd0, 64'd0, 1'b1));
      send_request(make_request(rtlm_pkg::OP_RECEIVE, rtlm_pkg::RESP_OP_RESET, 16'hFFFF,
                                64'hFFFF_FFFF_FFFF_FFFF, 1'b1));
      send_request(make_request(rtlm_pkg::OP_SEND,
                                rtlm_pkg::CANDIDATE_TABLE[rtlm_pkg::KNOWN_CANDIDATES - 1],
                                rtlm_pkg::REQ_LEN_RESET, 64'd100, 1'b0));
      send_request(make_request(rtlm_pkg::OP_MODE, 16'hFFFF, 16'hFFFF,
                                64'hFFFF_FFFF_FFFF_FFFF, 1'b0));
      send_request(make_request(rtlm_pkg::OP_RECEIVE, rtlm_pkg::RESP_OP_RESET, 16'd0,
                                64'd200, 1'b0));
      // exactly at the limit, then one microsecond over
      send_request(make_request(rtlm_pkg::OP_SEND,
                                rtlm_pkg::CANDIDATE_TABLE[rtlm_pkg::KNOWN_CANDIDATES - 1],
                                rtlm_pkg::REQ_LEN_RESET, 64'd1000, 1'b0));
      send_request(make_request(rtlm_pkg::OP_RECEIVE, rtlm_pkg::RESP_OP_RESET, 16'd0,
                                64'd15_001_000, 1'b0));
      send_request(make_request(rtlm_pkg::OP_SEND,
                                rtlm_pkg::CANDIDATE_TABLE[rtlm_pkg::KNOWN_CANDIDATES - 1],
                                rtlm_pkg::REQ_LEN_RESET, 64'd0, 1'b0));
      send_request(make_request(rtlm_pkg::OP_RECEIVE, rtlm_pkg::RESP_OP_RESET, 16'd0,
                                64'd15_000_010, 1'b0));
   endtask

   initial begin
      sb = new;
      sb.reset_state();
      reset                 = 1'b1;
      csr_write_en          = 1'b0;
      csr_index             = '0;
      csr_write_data        = '0;
      req_bus.valid         = 1'b0;
      req_bus.operation     = '0;
      req_bus.packet_opcode = '0;
      req_bus.packet_length = '0;
      req_bus.event_time    = '0;
      req_bus.entering_game = 1'b0;
      sender_idle_pct       = 0;
      receiver_stall_pct    = 0;
      hold_request          = 0;
      quiet_cycles          = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      run_directed();
      run_phase(rtlm_pkg::FREQ_RESET, rtlm_pkg::LIMIT_RESET, rtlm_pkg::RESP_OP_RESET,
                rtlm_pkg::REQ_LEN_RESET, 0, 0, 0);
      run_phase(32'd1, 24'hFFFFFF, 16'h0000, 16'h0000, 56, 0, 0);
      run_phase(32'hFFFF_FFFF, 24'd0, 16'hFFFF, 16'hFFFF, 0, 56, 300);
      run_phase(32'd0, 24'd1_000_000, rtlm_pkg::RESP_OP_RESET, rtlm_pkg::REQ_LEN_RESET,
                9, 9, 0);
      run_phase(32'd25_000_000, 24'd1_500_000, 16'h8000, 16'h0040, 0, 56, 0);

      settle();
      if (sb.errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
